FILE: rtl/qtpd_pkg.sv
`timescale 1ns / 1ps

package qtpd_pkg;

  // Default number of runs the drive can hold waiting.
  localparam int QUEUE_DEPTH_DEF = 128;

  // Entries in the op queue between the classifier and the executor.
  localparam int OPQ_DEPTH = 4;
  localparam int OPQ_AW    = $clog2(OPQ_DEPTH);

  // Request kinds as carried on s_tuser.
  localparam logic [1:0] REQ_CMD   = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_SETID = 2'd2;

  // Command codes.
  localparam logic [7:0] CMD_START = 8'd0;
  localparam logic [7:0] CMD_STOP  = 8'd1;
  localparam logic [7:0] CMD_REV   = 8'd2;
  localparam logic [7:0] CMD_SPEED = 8'd3;

  localparam logic [6:0] SPEED_MAX   = 7'd100;
  localparam logic [7:0] DUTY_MAX    = 8'd255;
  // floor(x / 100) equals (x * 41944) >> 22 for every x below 43690.
  localparam logic [15:0] DUTY_RECIP = 16'd41944;
  localparam int          DUTY_SHIFT = 22;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_START,
    OP_STOP,
    OP_REV,
    OP_SPEED,
    OP_TICK,
    OP_SETID
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [31:0] arg;    // run length for start, new id for set-id
    logic [6:0]  speed;
    logic [7:0]  duty;
  } op_t;

endpackage

FILE: rtl/queued_timed_pump_drive.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Contents
// request   in   s_tvalid/s_tready  s_tdata, s_tuser (request kind)
// status    out  m_tvalid/m_tready  m_tdata, one per request
//
// One request is taken per cycle and one status leaves per cycle when the sink keeps up.
// A request is written into the op queue when it is accepted; the executor then pops it and
// loads its status register, from which the sink takes the status.
// The queued runs live in a single memory whose head entry is
// kept prefetched, so a run can start in the same request that frees the drive.
// Reset clears all control state; the run memory is not cleared and needs no pass.
// A stalled status register holds the executor; the op queue then fills and drops s_tready.
module queued_timed_pump_drive import qtpd_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // target_id[31:0], command[39:32], payload[71:40], new_id[103:72]
  input  logic [103:0] s_tdata,
  // req_type[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // pin_a_duty[7:0], pin_b_duty[15:8], running[16], pending_runs[24:17],
  // start_dropped[25], current_id[57:26], speed_percent[64:58], zeros above
  output logic [71:0]  m_tdata
);

  logic q_full;
  logic q_push;
  op_t  push_op;
  logic q_pop;
  logic q_valid;
  op_t  head_op;

  qtpd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_op     (push_op)
  );

  qtpd_opq u_opq (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .head_op (head_op)
  );

  qtpd_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (q_valid),
    .op       (head_op),
    .op_pop   (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

FILE: rtl/qtpd_front.sv
`timescale 1ns / 1ps

module qtpd_front import qtpd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,
  input  logic [1:0]   s_tuser,
  input  logic         q_full,
  output logic         q_push,
  output op_t          q_op
);

  logic [31:0] front_id;
  logic [31:0] target_id;
  logic [7:0]  command;
  logic [31:0] payload;
  logic [31:0] new_id;
  logic        id_match;
  logic [6:0]  pct;
  logic [14:0] scaled;
  logic [30:0] prod;

  assign target_id = s_tdata[31:0];
  assign command   = s_tdata[39:32];
  assign payload   = s_tdata[71:40];
  assign new_id    = s_tdata[103:72];

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready;

  // The front keeps its own copy of the device id so that matching is decided
  // in request order, ahead of the executor.
  assign id_match = (target_id == front_id);

  assign pct    = (payload > {25'd0, SPEED_MAX}) ? SPEED_MAX : payload[6:0];
  assign scaled = {pct, 8'd0} - {8'd0, pct};
  assign prod   = {16'd0, scaled} * {15'd0, DUTY_RECIP};

  always_comb begin
    q_op.kind  = OP_NOP;
    q_op.arg   = payload;
    q_op.speed = pct;
    q_op.duty  = prod[DUTY_SHIFT +: 8];
    case (s_tuser)
      REQ_CMD: begin
        if (id_match) begin
          case (command)
            CMD_START: q_op.kind = OP_START;
            CMD_STOP:  q_op.kind = OP_STOP;
            CMD_REV:   q_op.kind = OP_REV;
            CMD_SPEED: q_op.kind = OP_SPEED;
            default:   q_op.kind = OP_NOP;
          endcase
        end
      end
      REQ_TICK: q_op.kind = OP_TICK;
      REQ_SETID: begin
        q_op.arg = new_id;
        if (id_match) begin
          q_op.kind = OP_SETID;
        end
      end
      default: q_op.kind = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_id <= '0;
    end else if (q_push && q_op.kind == OP_SETID) begin
      front_id <= new_id;
    end
  end

endmodule

FILE: rtl/qtpd_opq.sv
`timescale 1ns / 1ps

module qtpd_opq import qtpd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic valid,
  output op_t  head_op
);

  op_t              entries [OPQ_DEPTH];
  logic [OPQ_AW-1:0] wr_ptr;
  logic [OPQ_AW-1:0] rd_ptr;
  logic [OPQ_AW:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == (OPQ_AW + 1)'(OPQ_DEPTH));
  assign valid   = (count != '0);
  assign head_op = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/qtpd_back.sv
`timescale 1ns / 1ps

module qtpd_back import qtpd_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        op_valid,
  input  op_t         op,
  output logic        op_pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [31:0]   mem [QUEUE_DEPTH];
  logic [31:0]   head_val;

  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic          running;
  logic          forever_run;
  logic [31:0]   time_left;
  logic          swapped;
  logic [6:0]    speed;
  logic [7:0]    duty;
  logic [31:0]   dev_id;

  logic [AW-1:0] head_next;
  logic [CW-1:0] count_next;
  logic          running_next;
  logic          forever_next;
  logic [31:0]   time_left_next;
  logic          swapped_next;
  logic [6:0]    speed_next;
  logic [7:0]    duty_next;
  logic [31:0]   dev_id_next;
  logic          dropped;

  logic          fire;
  logic          wr_en;
  logic [CW:0]   wr_sum;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [31:0]   launch_val;
  logic [31:0]   tl_dec;
  logic [7:0]    pin_a;
  logic [7:0]    pin_b;
  logic [7:0]    pending;

  assign fire   = op_valid && (!m_tvalid || m_tready);
  assign op_pop = fire;

  // Tail slot: head + count, wrapped once.
  assign wr_sum  = {{(CW + 1 - AW){1'b0}}, head} + {1'b0, count};
  assign wr_addr = (wr_sum >= (CW + 1)'(QUEUE_DEPTH)) ?
                   AW'(wr_sum - (CW + 1)'(QUEUE_DEPTH)) : AW'(wr_sum);
  assign tl_dec  = (time_left != '0) ? time_left - 32'd1 : time_left;

  always_comb begin
    head_next      = head;
    count_next     = count;
    running_next   = running;
    forever_next   = forever_run;
    time_left_next = time_left;
    swapped_next   = swapped;
    speed_next     = speed;
    duty_next      = duty;
    dev_id_next    = dev_id;
    dropped        = 1'b0;
    wr_en          = 1'b0;
    case (op.kind)
      OP_START: begin
        if (count < CW'(QUEUE_DEPTH)) begin
          wr_en      = 1'b1;
          count_next = count + 1'b1;
        end else begin
          dropped = 1'b1;
        end
      end
      OP_STOP: begin
        running_next   = 1'b0;
        forever_next   = 1'b0;
        time_left_next = '0;
        count_next     = '0;
      end
      OP_REV: swapped_next = !swapped;
      OP_SPEED: begin
        speed_next = op.speed;
        duty_next  = op.duty;
      end
      OP_TICK: begin
        if (running && !forever_run) begin
          time_left_next = tl_dec;
          if (tl_dec == '0) begin
            running_next = 1'b0;
            forever_next = 1'b0;
          end
        end
      end
      OP_SETID: dev_id_next = op.arg;
      default: ;
    endcase

    // A run just queued into an empty queue is taken straight from the request.
    launch_val = (count == '0) ? op.arg : head_val;
    if (!running_next && count_next != '0) begin
      head_next      = (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
      count_next     = count_next - 1'b1;
      running_next   = 1'b1;
      forever_next   = (launch_val == '0);
      time_left_next = launch_val;
    end

    pin_a   = (running_next && !swapped_next) ? duty_next : 8'd0;
    pin_b   = (running_next && swapped_next) ? duty_next : 8'd0;
    pending = 8'(count_next);
  end

  assign rd_addr = fire ? head_next : head;

  // head_val always mirrors the entry at the head; a write to that slot in the
  // same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (fire && wr_en) begin
      mem[wr_addr] <= op.arg;
    end
    if (fire && wr_en && wr_addr == rd_addr) begin
      head_val <= op.arg;
    end else begin
      head_val <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      count       <= '0;
      running     <= 1'b0;
      forever_run <= 1'b0;
      time_left   <= '0;
      swapped     <= 1'b0;
      speed       <= SPEED_MAX;
      duty        <= DUTY_MAX;
      dev_id      <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (fire) begin
        head        <= head_next;
        count       <= count_next;
        running     <= running_next;
        forever_run <= forever_next;
        time_left   <= time_left_next;
        swapped     <= swapped_next;
        speed       <= speed_next;
        duty        <= duty_next;
        dev_id      <= dev_id_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {7'd0, speed_next, dev_id_next, dropped, pending, running_next, pin_b, pin_a};
    end
  end

endmodule

FILE: rtl/qtpd_chk.sv
`timescale 1ns / 1ps

module qtpd_chk (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata
);

  // A status waiting on the sink must not change.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("status changed while stalled");

  // With the drive off, both pins must be dark.
  a_idle_pins: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[16] |-> m_tdata[15:0] == 16'd0)
    else $error("pin driven while idle");

  // Only one pin may carry duty at a time.
  a_one_pin: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:0] == 8'd0) || (m_tdata[15:8] == 8'd0))
    else $error("both pins driven");

  // A full queue can only happen while a run is active.
  a_drop_running: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[25] |-> m_tdata[16])
    else $error("start dropped while idle");

  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[64:58] <= 7'd100)
    else $error("speed above 100 percent");

endmodule

bind queued_timed_pump_drive qtpd_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
